FILE: rtl/cdnp_pkg.sv
// ----------------------------------------------------------------------------
// cdnp_pkg
// shared types and constants of the c declarator name parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdnp_pkg;

  localparam int unsigned MaxDims   = 4;   // dimensions recorded per name
  localparam int unsigned DimSlots  = 4;   // dimension fields in a result
  localparam int unsigned CharW     = 8;
  localparam int unsigned DimW      = 16;
  localparam int unsigned StarW     = 8;
  localparam int unsigned DimCntW   = 3;
  localparam int unsigned SizeW     = 32;
  localparam int unsigned OutDataW  = 112; // 108 field bits, padded to bytes

  localparam logic [CharW-1:0] CharNul          = 8'h00;
  localparam logic [CharW-1:0] CharZero         = 8'h30;
  localparam logic [CharW-1:0] CharNine         = 8'h39;
  localparam logic [CharW-1:0] CharOpenBracket  = 8'h5B;
  localparam logic [CharW-1:0] CharCloseBracket = 8'h5D;
  localparam logic [CharW-1:0] CharStar         = 8'h2A;
  localparam logic [CharW-1:0] CharOpenParen    = 8'h28;
  localparam int unsigned      DecimalBase      = 10;

  // one character handed to the parser
  typedef struct packed {
    logic             fire;
    logic [CharW-1:0] ch;
  } cdnp_step_t;

  // summary of one finished name
  typedef struct packed {
    logic                           valid;
    logic [StarW-1:0]               pointer_count;
    logic                           is_function_pointer;
    logic [DimCntW-1:0]             dimension_count;
    logic [SizeW-1:0]               array_size;
    logic [DimSlots-1:0][DimW-1:0]  dims;
  } cdnp_result_t;

endpackage

`default_nettype wire

FILE: rtl/cdnp_parse.sv
// ----------------------------------------------------------------------------
// cdnp_parse
// per-character state update and summary build on the terminator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdnp_parse (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  cdnp_pkg::cdnp_step_t  step_i,
  output cdnp_pkg::cdnp_result_t result_o
);

  logic                                               in_bracket_q, in_bracket_d;
  logic [cdnp_pkg::DimW-1:0]                          acc_q, acc_d;
  logic [cdnp_pkg::StarW-1:0]                         star_q, star_d;
  logic                                               func_q, func_d;
  logic [cdnp_pkg::DimCntW-1:0]                       dim_index_q, dim_index_d;
  logic [cdnp_pkg::DimSlots-1:0][cdnp_pkg::DimW-1:0]  store_q, store_d;
  logic [cdnp_pkg::SizeW-1:0]                         size_q, size_d;

  logic                                               is_digit;
  logic [3:0]                                         digit_val;
  logic [cdnp_pkg::DimW+3:0]                          acc_mul;
  logic [cdnp_pkg::DimW-1:0]                          acc_next;
  logic                                               can_record;
  logic [cdnp_pkg::SizeW+cdnp_pkg::DimW-1:0]          prod;
  logic [cdnp_pkg::SizeW-1:0]                         close_size;
  logic [cdnp_pkg::DimSlots-1:0][cdnp_pkg::DimW-1:0]  close_store;
  logic [cdnp_pkg::DimCntW-1:0]                       close_index;

  // digit accumulate, saturating at the top of the dimension range
  assign is_digit  = (step_i.ch >= cdnp_pkg::CharZero) && (step_i.ch <= cdnp_pkg::CharNine);
  assign digit_val = step_i.ch[3:0] - cdnp_pkg::CharZero[3:0];
  assign acc_mul   = ({4'd0, acc_q} * (cdnp_pkg::DimW+4)'(cdnp_pkg::DecimalBase))
                   + {{cdnp_pkg::DimW{1'b0}}, digit_val};
  assign acc_next  = (|acc_mul[cdnp_pkg::DimW+3:cdnp_pkg::DimW]) ? '1
                                                                  : acc_mul[cdnp_pkg::DimW-1:0];

  // closing a bracket: record dimension and fold it into the size
  assign can_record = dim_index_q < cdnp_pkg::DimCntW'(cdnp_pkg::MaxDims);
  assign prod       = (cdnp_pkg::SizeW+cdnp_pkg::DimW)'(size_q)
                    * (cdnp_pkg::SizeW+cdnp_pkg::DimW)'(acc_q);

  always_comb begin
    close_store = store_q;
    for (int i = 0; i < int'(cdnp_pkg::DimSlots); i++) begin
      if (can_record && (dim_index_q == cdnp_pkg::DimCntW'(i))) begin
        close_store[i] = acc_q;
      end
    end
    if (can_record) begin
      close_size  = (|prod[cdnp_pkg::SizeW+cdnp_pkg::DimW-1:cdnp_pkg::SizeW]) ? '1
                                                               : prod[cdnp_pkg::SizeW-1:0];
      close_index = dim_index_q + cdnp_pkg::DimCntW'(1);
    end else begin
      close_size  = size_q;
      close_index = dim_index_q;
    end
  end

  always_comb begin
    in_bracket_d = in_bracket_q;
    acc_d        = acc_q;
    star_d       = star_q;
    func_d       = func_q;
    dim_index_d  = dim_index_q;
    store_d      = store_q;
    size_d       = size_q;

    result_o                     = '0;
    result_o.pointer_count       = star_q;
    result_o.is_function_pointer = func_q;
    if (in_bracket_q) begin
      // open bracket at the end is closed first
      result_o.dimension_count = close_index;
      result_o.array_size      = close_size;
      result_o.dims            = close_store;
    end else begin
      result_o.dimension_count = dim_index_q;
      result_o.array_size      = size_q;
      result_o.dims            = store_q;
    end

    if (step_i.fire) begin
      if (step_i.ch == cdnp_pkg::CharNul) begin
        result_o.valid = 1'b1;
        in_bracket_d   = 1'b0;
        acc_d          = '0;
        star_d         = '0;
        func_d         = 1'b0;
        dim_index_d    = '0;
        store_d        = '0;
        size_d         = cdnp_pkg::SizeW'(1);
      end else if (in_bracket_q) begin
        if (step_i.ch == cdnp_pkg::CharCloseBracket) begin
          in_bracket_d = 1'b0;
          acc_d        = '0;
          dim_index_d  = close_index;
          store_d      = close_store;
          size_d       = close_size;
        end else if (is_digit) begin
          acc_d = acc_next;
        end
      end else if (step_i.ch == cdnp_pkg::CharStar) begin
        if (star_q != '1) begin
          star_d = star_q + cdnp_pkg::StarW'(1);
        end
      end else if (step_i.ch == cdnp_pkg::CharOpenParen) begin
        func_d = 1'b1;
      end else if (step_i.ch == cdnp_pkg::CharOpenBracket) begin
        in_bracket_d = 1'b1;
        acc_d        = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bracket_q <= 1'b0;
      acc_q        <= '0;
      star_q       <= '0;
      func_q       <= 1'b0;
      dim_index_q  <= '0;
      store_q      <= '0;
      size_q       <= cdnp_pkg::SizeW'(1);
    end else begin
      in_bracket_q <= in_bracket_d;
      acc_q        <= acc_d;
      star_q       <= star_d;
      func_q       <= func_d;
      dim_index_q  <= dim_index_d;
      store_q      <= store_d;
      size_q       <= size_d;
    end
  end

  // state is back to reset after a name ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.fire && (step_i.ch == cdnp_pkg::CharNul)) |=>
      (star_q == '0) && (dim_index_q == '0) && !in_bracket_q && (acc_q == '0)
      && (size_q == cdnp_pkg::SizeW'(1)) && !func_q)
    else $error("parser state not cleared after terminator");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dim_index_q <= cdnp_pkg::DimCntW'(cdnp_pkg::MaxDims))
    else $error("dimension index beyond limit");

endmodule

`default_nettype wire

FILE: rtl/cdnp_out_buf.sv
// ----------------------------------------------------------------------------
// cdnp_out_buf
// result register with stream handshake and field packing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdnp_out_buf (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  cdnp_pkg::cdnp_result_t            result_i,
  output logic                              free_o,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [cdnp_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic                          valid_q, valid_d;
  logic [cdnp_pkg::OutDataW-1:0] data_q, data_d;

  // slot can take a new result when empty or drained this cycle
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (result_i.valid) begin
      valid_d = 1'b1;
      data_d  = {4'd0,
                 result_i.dims[3], result_i.dims[2], result_i.dims[1], result_i.dims[0],
                 result_i.array_size, result_i.dimension_count,
                 result_i.is_function_pointer, result_i.pointer_count};
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

`default_nettype wire

FILE: rtl/c_declarator_name_parser_core.sv
// ----------------------------------------------------------------------------
// c_declarator_name_parser_core
// streaming parser for c member declarator names
// ----------------------------------------------------------------------------
// Takes one character of a declarator name such as "*next[4][8]" per beat and
// sustains one beat per clock. A zero byte ends the name and yields one
// summary beat: pointer level, function-pointer flag, dimension count, the
// saturating product of the dimensions and the first four dimensions. The
// summary passes through the input register and then the result register.
// Input is only held back when a terminator sits in the input register
// while the result register still holds a summary that has not been taken;
// ordinary characters produce no output and keep flowing even under output
// backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c_declarator_name_parser_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input stream, tdata: char_in [7:0]
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire  [cdnp_pkg::CharW-1:0]        s_axis_tdata,
  // output stream, tdata: pointer_count [7:0], is_function_pointer [8],
  // dimension_count [11:9], array_size [43:12], dim_first [59:44],
  // dim_second [75:60], dim_third [91:76], dim_fourth [107:92], zero pad
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [cdnp_pkg::OutDataW-1:0]     m_axis_tdata
);

  // input register
  logic                          in_valid_q, in_valid_d;
  logic [cdnp_pkg::CharW-1:0]    in_char_q, in_char_d;

  logic                          out_free;
  logic                          take;
  cdnp_pkg::cdnp_step_t          step;
  cdnp_pkg::cdnp_result_t        result;

  // a held character moves on unless it is a terminator facing a full slot
  assign take          = (in_char_q != cdnp_pkg::CharNul) || out_free;
  assign s_axis_tready = !in_valid_q || take;

  assign step.fire = in_valid_q && take;
  assign step.ch   = in_char_q;

  always_comb begin
    in_valid_d = in_valid_q;
    in_char_d  = in_char_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
      in_char_d  = s_axis_tdata;
    end else if (step.fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_char_q <= in_char_d;
  end

  // character state update and summary build
  cdnp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_o (result)
  );

  // result register toward the output stream
  cdnp_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // summaries only come from a terminator, and only into a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid |-> (in_char_q == cdnp_pkg::CharNul) && out_free)
    else $error("summary built without terminator or free slot");

  // a blocked terminator waits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && (in_char_q == cdnp_pkg::CharNul) && !out_free) |=>
      in_valid_q && (in_char_q == cdnp_pkg::CharNul))
    else $error("blocked terminator lost");

  // backpressure on the input only comes from a held terminator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && (in_char_q == cdnp_pkg::CharNul))
    else $error("input stalled without a pending terminator");

endmodule

`default_nettype wire
